// ===== rtl/core/alub_pkg.sv =====
// alub_pkg: opcodes, stage payload type and sizes for the alu with booth multiplier
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package alub_pkg;

   localparam int unsigned OpndWidth = 8;
   localparam int unsigned ResWidth  = 16;
   localparam int unsigned NumCells  = OpndWidth;   // one booth step per cell
   localparam int unsigned AccWidth  = OpndWidth + 1;

   localparam logic [OpndWidth-1:0] OpAdd = 8'h01;
   localparam logic [OpndWidth-1:0] OpSub = 8'h02;
   localparam logic [OpndWidth-1:0] OpMul = 8'h03;
   localparam logic [OpndWidth-1:0] OpAnd = 8'h04;
   localparam logic [OpndWidth-1:0] OpOr  = 8'h05;
   localparam logic [OpndWidth-1:0] OpNot = 8'h06;
   localparam logic [OpndWidth-1:0] OpXor = 8'h07;
   localparam logic [OpndWidth-1:0] OpShr = 8'h08;
   localparam logic [OpndWidth-1:0] OpShl = 8'h09;

   localparam logic [ResWidth-1:0] InvalidResult = 16'hFFFF;

   // payload carried down the cell chain
   typedef struct packed {
      logic [AccWidth-1:0]  acc;
      logic [OpndWidth-1:0] q;
      logic                 q_1;
      logic [AccWidth-1:0]  m;
      logic                 mul;
      logic [ResWidth-1:0]  res;
      logic                 bad;
   } stage_type;

endpackage

// ===== rtl/core/alu_8bit_booth_multiply.sv =====
// alu_8bit_booth_multiply: 8-bit alu with a radix-2 booth multiplier, top level
// depends on alub_pkg, alub_decode, alub_cell, alub_out
// Usage:
//   req channel: req_valid with req_command, req_operand_a, req_operand_b; a transfer
//   happens on a clock edge where req_valid is high and req_stall is low.
//   rsp channel: rsp_valid with rsp_result and the five flags; a transfer happens when
//   rsp_valid is high and rsp_stall is low. One response per request, in order.
//   The request is decoded on entry, then walks a chain of eight cells, each doing one
//   booth add/subtract and arithmetic shift; other opcodes ride the chain unchanged.
//   A request passes the eight cells and then the response register before rsp_valid
//   rises. Throughput is one transfer per cycle for every opcode while rsp_stall is low.
//   Each cell advances when empty or when its successor advances, so a stalled
//   receiver first fills the bubbles; req_stall rises only once every stage is full.
//   A stalled response holds its value.
//   Synchronous reset empties all stages; rsp_valid is low the cycle after reset.
`timescale 1ns / 1ps

module alu_8bit_booth_multiply
   import alub_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OpndWidth-1:0] req_command,
   input  logic [OpndWidth-1:0] req_operand_a,
   input  logic [OpndWidth-1:0] req_operand_b,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ResWidth-1:0]  rsp_result,
   output logic                 rsp_invalid_op,
   output logic                 rsp_zero_flag,
   output logic                 rsp_sign_flag,
   output logic                 rsp_overflow_flag,
   output logic                 rsp_carry_flag
);

   stage_type chain_data  [NumCells+1];
   logic      chain_valid [NumCells+1];
   logic      chain_ready [NumCells+1];

   alub_decode u_decode (
      .command   (req_command),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .stage_out (chain_data[0])
   );

   assign chain_valid[0] = req_valid;
   assign req_stall      = !chain_ready[0];

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      alub_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   alub_out u_out (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (chain_valid[NumCells]),
      .in_ready          (chain_ready[NumCells]),
      .in_data           (chain_data[NumCells]),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result        (rsp_result),
      .rsp_invalid_op    (rsp_invalid_op),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_carry_flag    (rsp_carry_flag)
   );

   // an invalid opcode always returns the all-ones pattern
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid_op |-> rsp_result == InvalidResult)
      else $error("invalid opcode response without all-ones result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_carry_flag |-> rsp_overflow_flag)
      else $error("carry flag set without overflow flag");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the receiver free the chain never pushes back
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(rsp_stall) |-> !req_stall)
      else $error("request stalled while the response register is empty");

endmodule

// ===== rtl/core/alub_decode.sv =====
// alub_decode: opcode decode, single-step operations and booth start values
// depends on alub_pkg
`timescale 1ns / 1ps

module alub_decode
   import alub_pkg::*;
(
   input  logic [OpndWidth-1:0] command,
   input  logic [OpndWidth-1:0] operand_a,
   input  logic [OpndWidth-1:0] operand_b,
   output stage_type            stage_out
);

   logic [OpndWidth:0] sum;

   assign sum = {1'b0, operand_a} + {1'b0, operand_b};

   always_comb begin
      stage_out.acc = '0;
      stage_out.q   = operand_b;
      stage_out.q_1 = 1'b0;
      stage_out.m   = {operand_a[OpndWidth-1], operand_a};
      stage_out.mul = 1'b0;
      stage_out.bad = 1'b0;
      stage_out.res = '0;
      case (command)
         OpAdd: begin
            stage_out.res = {{(ResWidth-OpndWidth-1){1'b0}}, sum};
         end
         OpSub: begin
            stage_out.res = {{(ResWidth-OpndWidth){1'b0}}, operand_a}
                          - {{(ResWidth-OpndWidth){1'b0}}, operand_b};
         end
         OpMul: begin
            stage_out.mul = 1'b1;
         end
         OpAnd: begin
            stage_out.res = {{(ResWidth-OpndWidth){1'b0}}, operand_a & operand_b};
         end
         OpOr: begin
            stage_out.res = {{(ResWidth-OpndWidth){1'b0}}, operand_a | operand_b};
         end
         OpNot: begin
            stage_out.res = {{(ResWidth-OpndWidth){1'b0}}, ~operand_a};
         end
         OpXor: begin
            stage_out.res = {{(ResWidth-OpndWidth){1'b0}}, operand_a ^ operand_b};
         end
         OpShr: begin
            stage_out.res = {{(ResWidth-OpndWidth+1){1'b0}}, operand_a[OpndWidth-1:1]};
         end
         OpShl: begin
            stage_out.res = {{(ResWidth-OpndWidth){1'b0}}, operand_a[OpndWidth-2:0], 1'b0};
         end
         default: begin
            stage_out.res = InvalidResult;
            stage_out.bad = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/alub_cell.sv =====
// alub_cell: one registered booth step; non-multiply items pass through unchanged
// depends on alub_pkg
`timescale 1ns / 1ps

module alub_cell
   import alub_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   logic [AccWidth-1:0] acc_sum;
   logic      advance;

   // stage moves when empty or when the next one takes its item
   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = in_valid;

   always_comb begin
      acc_sum = in_data.acc;
      if (in_data.q[0] && !in_data.q_1) begin
         acc_sum = in_data.acc - in_data.m;
      end else if (!in_data.q[0] && in_data.q_1) begin
         acc_sum = in_data.acc + in_data.m;
      end
      data_in = in_data;
      if (in_data.mul) begin
         data_in.q_1 = in_data.q[0];
         data_in.q   = {acc_sum[0], in_data.q[OpndWidth-1:1]};
         data_in.acc = {acc_sum[AccWidth-1], acc_sum[AccWidth-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/alub_out.sv =====
// alub_out: picks the final result, derives the flags and holds the response register
// depends on alub_pkg
`timescale 1ns / 1ps

module alub_out
   import alub_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  stage_type           in_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ResWidth-1:0] rsp_result,
   output logic                rsp_invalid_op,
   output logic                rsp_zero_flag,
   output logic                rsp_sign_flag,
   output logic                rsp_overflow_flag,
   output logic                rsp_carry_flag
);

   logic                valid_ff;
   logic [ResWidth-1:0] result_ff;
   logic [ResWidth-1:0] result_in;
   logic                bad_ff;
   logic                advance;

   assign advance  = !valid_ff || !rsp_stall;
   assign in_ready = advance;

   // product is the accumulator's low bits over the shifted multiplier
   assign result_in = in_data.mul ? {in_data.acc[OpndWidth-1:0], in_data.q} : in_data.res;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
         bad_ff    <= in_data.bad;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result        = result_ff;
   assign rsp_invalid_op    = bad_ff;
   assign rsp_zero_flag     = (result_ff == '0);
   assign rsp_sign_flag     = result_ff[OpndWidth-1];
   assign rsp_overflow_flag = |result_ff[ResWidth-1:OpndWidth-1];
   assign rsp_carry_flag    = |result_ff[ResWidth-1:OpndWidth];

endmodule

// ===== dv/alub_result_checker.sv =====
// alub_result_checker: watches both channels of the alu, predicts each response and compares it
// depends on alub_pkg for operand and result widths and for the opcodes
`timescale 1ns / 1ps

module alub_result_checker
   import alub_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [OpndWidth-1:0] req_command,
   input  logic [OpndWidth-1:0] req_operand_a,
   input  logic [OpndWidth-1:0] req_operand_b,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [ResWidth-1:0]  rsp_result,
   input  logic                 rsp_invalid_op,
   input  logic                 rsp_zero_flag,
   input  logic                 rsp_sign_flag,
   input  logic                 rsp_overflow_flag,
   input  logic                 rsp_carry_flag,
   output int                   mismatch_count,
   output int                   outstanding,
   output int                   responses_checked
);

   typedef struct packed {
      logic [ResWidth-1:0] result;
      logic                invalid_op;
      logic                zero;
      logic                sign;
      logic                overflow;
      logic                carry;
   } alu_outcome_type;

   alu_outcome_type pending_results[$];

   initial begin
      mismatch_count    = 0;
      outstanding       = 0;
      responses_checked = 0;
   end

   function automatic alu_outcome_type alu_predict(input logic [OpndWidth-1:0] cmd,
                                                   input logic [OpndWidth-1:0] a,
                                                   input logic [OpndWidth-1:0] b);
      alu_outcome_type       o;
      logic [ResWidth-1:0]   r;
      logic signed [ResWidth-1:0] sa;
      logic signed [ResWidth-1:0] sb;
      sa           = $signed(a);
      sb           = $signed(b);
      o.invalid_op = 1'b0;
      case (cmd)
         OpAdd: r = {8'h00, a} + {8'h00, b};
         OpSub: r = {8'h00, a} - {8'h00, b};
         OpMul: r = sa * sb;
         OpAnd: r = {8'h00, a & b};
         OpOr:  r = {8'h00, a | b};
         OpNot: r = {8'h00, ~a};
         OpXor: r = {8'h00, a ^ b};
         OpShr: r = {8'h00, a >> 1};
         OpShl: r = {8'h00, 8'(a << 1)};
         default: begin
            r            = InvalidResult;
            o.invalid_op = 1'b1;
         end
      endcase
      o.result   = r;
      o.zero     = (r == '0);
      o.sign     = r[7];
      o.overflow = (r > 16'h007F);
      o.carry    = (r > 16'h00FF);
      return o;
   endfunction

   task automatic note_mismatch(input string why, input alu_outcome_type want,
                                input alu_outcome_type got);
      if (mismatch_count < 10) begin
         $display("%0t mismatch (%s): expected res=%h inv=%b z=%b s=%b o=%b c=%b",
                  $realtime, why, want.result, want.invalid_op, want.zero, want.sign,
                  want.overflow, want.carry);
         $display("   got res=%h inv=%b z=%b s=%b o=%b c=%b",
                  got.result, got.invalid_op, got.zero, got.sign, got.overflow, got.carry);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      alu_outcome_type want;
      alu_outcome_type got;
      if (reset) begin
         pending_results.delete();
         outstanding <= 0;
      end else begin
         if (req_valid && !req_stall)
            pending_results.push_back(alu_predict(req_command, req_operand_a, req_operand_b));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_result, rsp_invalid_op, rsp_zero_flag, rsp_sign_flag,
                    rsp_overflow_flag, rsp_carry_flag};
            if (pending_results.size() == 0) begin
               note_mismatch("response with nothing pending", '0, got);
            end else begin
               want = pending_results.pop_front();
               responses_checked++;
               if (want.result !== got.result || want.invalid_op !== got.invalid_op ||
                   want.zero !== got.zero || want.sign !== got.sign ||
                   want.overflow !== got.overflow || want.carry !== got.carry)
                  note_mismatch("field", want, got);
            end
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

// ===== dv/tb.sv =====
// tb: drives random and directed alu requests with gaps and back-pressure, gives the verdict
// depends on alub_pkg, alu_8bit_booth_multiply and alub_result_checker
`timescale 1ns / 1ps

module tb;
   import alub_pkg::*;

   localparam int RandomItems = 1280;
   localparam int StallLimit  = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OpndWidth-1:0] req_command = '0;
   logic [OpndWidth-1:0] req_operand_a = '0;
   logic [OpndWidth-1:0] req_operand_b = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ResWidth-1:0]  rsp_result;
   logic                 rsp_invalid_op;
   logic                 rsp_zero_flag;
   logic                 rsp_sign_flag;
   logic                 rsp_overflow_flag;
   logic                 rsp_carry_flag;

   int   mismatch_count;
   int   outstanding;
   int   responses_checked;
   logic steady = 1'b0;
   int   mul_sent = 0;
   int   bad_sent = 0;

   always #1 clock = ~clock;

   alu_8bit_booth_multiply i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_operand_a,
      .req_operand_b, .rsp_valid, .rsp_stall, .rsp_result, .rsp_invalid_op,
      .rsp_zero_flag, .rsp_sign_flag, .rsp_overflow_flag, .rsp_carry_flag
   );

   alub_result_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_operand_a,
      .req_operand_b, .rsp_valid, .rsp_stall, .rsp_result, .rsp_invalid_op,
      .rsp_zero_flag, .rsp_sign_flag, .rsp_overflow_flag, .rsp_carry_flag,
      .mismatch_count, .outstanding, .responses_checked
   );

   // receiver back-pressure, off during the steady stretch
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 22);
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_op(input logic [OpndWidth-1:0] cmd, input logic [OpndWidth-1:0] a,
                          input logic [OpndWidth-1:0] b);
      logic taken;
      if (!steady) begin
         while ($urandom_range(99) < 22) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      if (cmd == OpMul) mul_sent++;
      if (cmd == 8'h00 || cmd > OpShl) bad_sent++;
      do begin
         @(posedge clock);
         taken = !req_stall;
         @(negedge clock);
      end while (!taken);
   endtask

   // sender holds off until every pending response is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic [OpndWidth-1:0] pick_operand();
      logic [OpndWidth-1:0] corners[5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
      if ($urandom_range(99) < 20) return corners[$urandom_range(4)];
      return OpndWidth'($urandom_range(255));
   endfunction

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < StallLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [OpndWidth-1:0] cmd;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners: carries, borrows, booth extremes, unary ops with junk b, bad opcodes
      send_op(OpAdd, 8'h00, 8'h00);
      send_op(OpAdd, 8'hFF, 8'hFF);
      send_op(OpAdd, 8'h7F, 8'h01);
      send_op(OpSub, 8'h00, 8'h01);
      send_op(OpSub, 8'h5A, 8'h5A);
      send_op(OpSub, 8'hFF, 8'h00);
      send_op(OpMul, 8'h80, 8'h80);
      send_op(OpMul, 8'h80, 8'h7F);
      send_op(OpMul, 8'h7F, 8'h7F);
      send_op(OpMul, 8'hFF, 8'hFF);
      send_op(OpMul, 8'h80, 8'h01);
      send_op(OpMul, 8'h00, 8'hA5);
      send_op(OpAnd, 8'hAA, 8'h55);
      send_op(OpAnd, 8'hFF, 8'hFF);
      send_op(OpOr,  8'h00, 8'h00);
      send_op(OpOr,  8'hAA, 8'h55);
      send_op(OpNot, 8'h00, 8'hC3);
      send_op(OpNot, 8'hFF, 8'h3C);
      send_op(OpXor, 8'hFF, 8'h0F);
      send_op(OpShr, 8'h01, 8'hFF);
      send_op(OpShr, 8'hFF, 8'h00);
      send_op(OpShl, 8'h80, 8'h77);
      send_op(OpShl, 8'hFF, 8'h00);
      send_op(8'h00, 8'h12, 8'h34);
      send_op(8'h0A, 8'hFF, 8'hFF);
      send_op(8'hFF, 8'h00, 8'h00);
      drain();

      for (int n = 0; n < RandomItems; n++) begin
         steady = (n >= 400 && n < 700);
         if (n == 900) drain();
         if ($urandom_range(99) < 15) begin
            do cmd = OpndWidth'($urandom_range(255)); while (cmd >= OpAdd && cmd <= OpShl);
         end else begin
            cmd = OpndWidth'($urandom_range(OpShl, OpAdd));
         end
         send_op(cmd, pick_operand(), pick_operand());
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (12) @(negedge clock);

      $display("checked %0d responses over all nine opcodes and bad ones (%0d multiplies, %0d bad opcodes)",
               responses_checked, mul_sent, bad_sent);
      $display("with random gaps and back-pressure on both channels, a steady stretch and two drains");
      if (mismatch_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
